[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files.
// Each macro expands to one labelled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/bllc_pkg.sv]
package bllc_pkg;

  localparam int CHAR_W       = 8;
  localparam int COUNT_W      = 21;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_INDEX_W  = 2;
  localparam int QUEUE_DEPTH  = 4;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = CFG_INDEX_W'(1);

  localparam logic [CHAR_W-1:0] CHAR_LAND  = 8'd35;
  localparam logic [CHAR_W-1:0] CHAR_WATER = 8'd46;

  // Class of one grid cell.
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_LAND  = 2'd1,
    CLS_WATER = 2'd2
  } cls_t;

  // One line store entry: the class two rows up and the class one row up.
  typedef struct packed {
    cls_t prev2;
    cls_t prev;
  } line_entry_t;

  // Per-word information handed from the front end to the back end.
  typedef struct packed {
    cls_t cls;
    logic row_ge1;
    logic row_ge2;
    logic last_row;
    logic row_end;
    logic col_ge1;
    logic col_ge2;
  } cell_flags_t;

endpackage

[hdl/bllc_if.sv]
interface bllc_char_if;
  logic                         valid;
  logic                         ready;
  logic [bllc_pkg::CHAR_W-1:0]  cell_char;

  modport source (output valid, output cell_char, input ready);
  modport sink   (input valid, input cell_char, output ready);
endinterface

interface bllc_count_if;
  logic                         valid;
  logic                         ready;
  logic [bllc_pkg::COUNT_W-1:0] coast_count;

  modport source (output valid, output coast_count, input ready);
  modport sink   (input valid, input coast_count, output ready);
endinterface

[hdl/bllc_ram.sv]
module bllc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/bllc_front.sv]
`include "assert_macros.svh"

module bllc_front #(
  parameter int MAX_COLS = bllc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = bllc_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bllc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bllc_pkg::CFG_DATA_W-1:0]     cfg_data,
  bllc_char_if.sink                           in_ch,
  input  logic                                q_ready,
  output logic                                push,
  output bllc_pkg::cell_flags_t               push_flags,
  output logic [$clog2(MAX_COLS)-1:0]         push_col,
  output logic [$clog2(MAX_COLS)-1:0]         push_raddr,
  output logic                                frame_restart
);

  import bllc_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW = CW + 2;

  logic [RW-1:0] row_pos;
  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_last;
  logic [CW-1:0] col_last;
  logic [RW-1:0] row_last_next;
  logic [CW-1:0] col_last_next;

  logic          row_end;
  logic          last_row;
  logic [AW-1:0] ahead;
  logic [AW-1:0] ahead_1;
  logic [AW-1:0] ahead_2;
  logic [AW-1:0] width;
  cls_t          cls;

  assign frame_restart = cfg_we && (cfg_index == CFG_ROW_COUNT ||
                                    cfg_index == CFG_COLUMN_COUNT);

  // Sizes are kept as the index of the last row and column, clamped to the range.
  always_comb begin
    if (cfg_data == '0) begin
      row_last_next = '0;
      col_last_next = '0;
    end else begin
      row_last_next = (cfg_data > MAX_ROWS) ? RW'(MAX_ROWS - 1)
                                            : RW'(cfg_data - CFG_DATA_W'(1));
      col_last_next = (cfg_data > MAX_COLS) ? CW'(MAX_COLS - 1)
                                            : CW'(cfg_data - CFG_DATA_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_last <= '0;
      col_last <= '0;
    end else if (cfg_we && cfg_index == CFG_ROW_COUNT) begin
      row_last <= row_last_next;
    end else if (cfg_we && cfg_index == CFG_COLUMN_COUNT) begin
      col_last <= col_last_next;
    end
  end

  assign in_ch.ready = q_ready;
  assign push        = in_ch.valid && q_ready;

  assign row_end  = (col_pos == col_last);
  assign last_row = (row_pos == row_last);

  always_ff @(posedge clk) begin
    if (rst || frame_restart) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (push) begin
      if (row_end) begin
        col_pos <= '0;
        row_pos <= last_row ? '0 : row_pos + RW'(1);
      end else begin
        col_pos <= col_pos + CW'(1);
      end
    end
  end

  always_comb begin
    unique case (in_ch.cell_char)
      CHAR_LAND:  cls = CLS_LAND;
      CHAR_WATER: cls = CLS_WATER;
      default:    cls = CLS_NONE;
    endcase
  end

  // The line store is read two columns ahead, wrapping into the next row.
  assign width   = AW'(col_last) + AW'(1);
  assign ahead   = AW'(col_pos) + AW'(2);
  assign ahead_1 = (ahead >= width) ? ahead - width : ahead;
  assign ahead_2 = (ahead_1 >= width) ? ahead_1 - width : ahead_1;

  assign push_raddr          = CW'(ahead_2);
  assign push_col            = col_pos;
  assign push_flags.cls      = cls;
  assign push_flags.row_ge1  = (row_pos != '0);
  assign push_flags.row_ge2  = (row_pos > RW'(1));
  assign push_flags.last_row = last_row;
  assign push_flags.row_end  = row_end;
  assign push_flags.col_ge1  = (col_pos != '0);
  assign push_flags.col_ge2  = (col_pos > CW'(1));

  `ASSERT_ALWAYS(a_col_in_range, clk, rst, col_pos <= col_last, "column position past row end")
  `ASSERT_ALWAYS(a_row_in_range, clk, rst, row_pos <= row_last, "row position past frame end")

endmodule

[hdl/bllc_queue.sv]
`include "assert_macros.svh"

module bllc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bllc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             ready,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign ready    = (count != NW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, !push || ready, "push into a full queue")
  `ASSERT_ALWAYS(a_no_underflow, clk, rst, !pop || valid, "pop from an empty queue")

endmodule

[hdl/bllc_back.sv]
`include "assert_macros.svh"

module bllc_back #(
  parameter int MAX_COLS = bllc_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          frame_restart,
  input  logic                          q_valid,
  input  bllc_pkg::cell_flags_t         q_flags,
  input  logic [$clog2(MAX_COLS)-1:0]   q_col,
  input  logic [$clog2(MAX_COLS)-1:0]   q_raddr,
  output logic                          pop,
  bllc_count_if.source                  out_ch
);

  import bllc_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int EW = $bits(line_entry_t);

  line_entry_t          entry_l;
  line_entry_t          entry_c;
  line_entry_t          entry_r;
  line_entry_t          wr_entry;
  line_entry_t          byp_data;
  logic                 byp_hit;
  logic [EW-1:0]        rdata;
  cls_t                 newest;
  cls_t                 older;
  logic [COUNT_W-1:0]   total;
  logic [COUNT_W-1:0]   sum;
  logic [COUNT_W-1:0]   coast_count;
  logic                 out_valid;
  logic                 frame_end;
  logic                 j_above;
  logic                 j_left;
  logic                 j_last;
  logic [1:0]           inc;

  assign frame_end = q_flags.last_row && q_flags.row_end;
  assign pop       = q_valid && (!frame_end || !out_valid || out_ch.ready);

  assign wr_entry.prev2 = entry_c.prev;
  assign wr_entry.prev  = q_flags.cls;

  bllc_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk   (clk),
    .we    (pop),
    .waddr (q_col),
    .wdata (wr_entry),
    .re    (pop),
    .raddr (q_raddr),
    .rdata (rdata)
  );

  // A read that hits the column being written takes the new entry.
  assign entry_r = byp_hit ? byp_data : line_entry_t'(rdata);

  always_ff @(posedge clk) begin
    if (pop) begin
      byp_hit  <= (q_raddr == q_col);
      byp_data <= wr_entry;
      entry_l  <= entry_c;
      entry_c  <= (q_flags.row_end && !q_flags.col_ge1) ? wr_entry : entry_r;
      if (q_flags.row_end) begin
        newest <= CLS_NONE;
        older  <= CLS_NONE;
      end else begin
        newest <= q_flags.cls;
        older  <= newest;
      end
    end
  end

  // The cell above is complete now that the cell below has arrived.
  assign j_above = q_flags.row_ge1 && entry_c.prev == CLS_LAND &&
                   ((q_flags.row_ge2 && entry_c.prev2 == CLS_WATER) ||
                    q_flags.cls == CLS_WATER ||
                    (q_flags.col_ge1 && entry_l.prev == CLS_WATER) ||
                    (!q_flags.row_end && entry_r.prev == CLS_WATER));

  // In the last row the cell to the left is complete.
  assign j_left = q_flags.last_row && q_flags.col_ge1 && newest == CLS_LAND &&
                  ((q_flags.row_ge1 && entry_l.prev == CLS_WATER) ||
                   (q_flags.col_ge2 && older == CLS_WATER) ||
                   q_flags.cls == CLS_WATER);

  // The final cell of the frame is judged on arrival.
  assign j_last = frame_end && q_flags.cls == CLS_LAND &&
                  ((q_flags.row_ge1 && entry_c.prev == CLS_WATER) ||
                   (q_flags.col_ge1 && newest == CLS_WATER));

  assign inc = 2'(j_above) + 2'(j_left) + 2'(j_last);
  assign sum = total + COUNT_W'(inc);

  always_ff @(posedge clk) begin
    if (rst || frame_restart) begin
      total <= '0;
    end else if (pop) begin
      total <= frame_end ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && frame_end) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && frame_end) begin
      coast_count <= sum;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.coast_count = coast_count;

  `ASSERT_NEXT(a_frame_end_result, clk, rst, pop && frame_end, out_valid, "frame end gave no word")

endmodule

[hdl/boundary_land_cell_counter.sv]
// The total is offered in the cycle after the frame's last word is taken.
// Throughput: one word per cycle while the queue has room and the output is not holding
// back the frame's last word; the line store has one write and one read port, used once
// per word, and a four-entry queue separates the front end from the back end.
// Reset (rst, synchronous, active high) sets a 1 x 1 grid, clears positions, the running
// total, the queue and the output; the line store is not cleared and needs no clearing pass.
module boundary_land_cell_counter #(
  parameter int MAX_COLS = bllc_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = bllc_pkg::DEF_MAX_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bllc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bllc_pkg::CFG_DATA_W-1:0]  cfg_data,
  bllc_char_if.sink                        in_ch,
  bllc_count_if.source                     out_ch
);

  import bllc_pkg::*;

  // The grid arrives in raster order. The front end tracks the row and column, classifies
  // each character as land, water or neither, and works out which line store column the
  // back end must prefetch. Each word then waits in a short queue, so that a stalled
  // output only holds back the front end once the queue has filled.
  //
  // The back end keeps one line store whose entry for each column holds the classes of
  // the two rows above. A three-column window (left, centre, right) slides along it: the
  // right entry is read two columns ahead, so that a word can be judged in every cycle.
  // When a word arrives, the cell above it has all four neighbours and is judged; in the
  // last row the cell to the left is judged too, and the final cell is judged at once.
  // Cells outside the grid never count as water.
  //
  // A write to either size register restarts the frame.

  localparam int CW = $clog2(MAX_COLS);
  localparam int QW = $bits(cell_flags_t) + 2 * CW;

  logic                q_ready;
  logic                push;
  cell_flags_t         push_flags;
  logic [CW-1:0]       push_col;
  logic [CW-1:0]       push_raddr;
  logic                frame_restart;

  logic                q_valid;
  logic                pop;
  logic [QW-1:0]       q_data;
  cell_flags_t         q_flags;
  logic [CW-1:0]       q_col;
  logic [CW-1:0]       q_raddr;

  bllc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_ch         (in_ch),
    .q_ready       (q_ready),
    .push          (push),
    .push_flags    (push_flags),
    .push_col      (push_col),
    .push_raddr    (push_raddr),
    .frame_restart (frame_restart)
  );

  bllc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_flags, push_col, push_raddr}),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop_data  (q_data),
    .pop       (pop)
  );

  assign {q_flags, q_col, q_raddr} = q_data;

  bllc_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .frame_restart (frame_restart),
    .q_valid       (q_valid),
    .q_flags       (q_flags),
    .q_col         (q_col),
    .q_raddr       (q_raddr),
    .pop           (pop),
    .out_ch        (out_ch)
  );

endmodule

[test/testbench.sv]
`default_nettype none

// Checks the coastline counter against an independent prediction.
// A driver sends grid characters from a queue, one word per handshake. A
// monitor collects the per-frame totals. Every accepted character is fed to
// the prediction below, and every frame it closes leaves one expected total.
// The run starts with a few hand-made grids, then goes through random frames
// under four idling modes, frames broken off by register writes, and the
// start of a frame whose size registers lie above the limit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bllc_pkg::*;

  // Indexes beyond the register list. Writing one must leave the frame alone.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = CFG_INDEX_W'(3);

  // Cycles allowed after the last expected total before the block counts as
  // idle, so that words still waiting in the four-entry queue can drain and
  // the registered total behind it can settle.
  localparam int SETTLE_CYCLES = 8;
  // Cycles with no handshake and no register write before the run gives up.
  localparam int QUIET_LIMIT = 1000;

  // Idling modes: none, sender only, receiver only, both.
  localparam int SEND_IDLE_PCT  [4] = '{0, 50, 0, 38};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 50, 38};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bllc_char_if  char_bus ();
  bllc_count_if count_bus ();

  boundary_land_cell_counter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (char_bus),
    .out_ch    (count_bus)
  );

  always #5 clk = ~clk;

  // Characters waiting to be sent, and totals waiting to come back.
  logic [CHAR_W-1:0]  pending_chars [$];
  logic [COUNT_W-1:0] coast_expected [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Predicted state of the block. The two line stores hold the classes of
  // the row above and of the row above that; the two left cells are the last
  // two classes of the current row.
  logic [CFG_DATA_W-1:0] grid_rows_reg = CFG_DATA_W'(1);
  logic [CFG_DATA_W-1:0] grid_cols_reg = CFG_DATA_W'(1);
  cls_t                  row_above  [DEF_MAX_COLS];
  cls_t                  row_above2 [DEF_MAX_COLS];
  cls_t                  left_newest = CLS_NONE;
  cls_t                  left_older = CLS_NONE;
  int unsigned           at_row = 0;
  int unsigned           at_col = 0;
  logic [COUNT_W-1:0]    coast_tally = '0;

  task automatic report_mismatch(string what);
    mismatches++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // A register value of zero acts as one, and one above the limit as the limit.
  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic cls_t class_of(logic [CHAR_W-1:0] ch);
    if (ch == CHAR_LAND) return CLS_LAND;
    if (ch == CHAR_WATER) return CLS_WATER;
    return CLS_NONE;
  endfunction

  function automatic void restart_frame();
    at_row = 0;
    at_col = 0;
    coast_tally = '0;
    left_newest = CLS_NONE;
    left_older = CLS_NONE;
  endfunction

  // A land cell counts when any of its four neighbours is water.
  function automatic void judge_cell(cls_t centre, cls_t up, cls_t down, cls_t lft, cls_t rgt);
    if (centre == CLS_LAND &&
        (up == CLS_WATER || down == CLS_WATER || lft == CLS_WATER || rgt == CLS_WATER)) begin
      coast_tally = coast_tally + 1'b1;
    end
  endfunction

  // Advances the prediction by one accepted character. A cell is judged as
  // soon as all its neighbours are known: the cell above on arrival of the
  // one below, and in the last row the cell to the left on arrival of its
  // right neighbour, the final cell on its own arrival.
  function automatic void predict_coast(logic [CHAR_W-1:0] ch);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    cls_t        cur;
    bit          last_row;
    bit          row_end;
    rows = clamp_dim(grid_rows_reg, DEF_MAX_ROWS);
    cols = clamp_dim(grid_cols_reg, DEF_MAX_COLS);
    r = at_row;
    c = at_col;
    cur = class_of(ch);
    last_row = (r == rows - 1);
    row_end = (c == cols - 1);

    if (r >= 1) begin
      judge_cell(row_above[c], (r >= 2) ? row_above2[c] : CLS_NONE, cur,
                 (c >= 1) ? row_above[c - 1] : CLS_NONE,
                 (c + 1 < cols) ? row_above[c + 1] : CLS_NONE);
    end
    if (last_row && c >= 1) begin
      judge_cell(left_newest, (r >= 1) ? row_above[c - 1] : CLS_NONE, CLS_NONE,
                 (c >= 2) ? left_older : CLS_NONE, cur);
    end
    if (last_row && row_end) begin
      judge_cell(cur, (r >= 1) ? row_above[c] : CLS_NONE, CLS_NONE,
                 (c >= 1) ? left_newest : CLS_NONE, CLS_NONE);
    end

    // The stores are written one column behind, so that the column to the
    // left of the current one still holds its old row when read.
    if (c >= 1) begin
      row_above2[c - 1] = row_above[c - 1];
      row_above[c - 1] = left_newest;
    end
    if (row_end) begin
      row_above2[c] = row_above[c];
      row_above[c] = cur;
      left_newest = CLS_NONE;
      left_older = CLS_NONE;
      at_col = 0;
      if (last_row) begin
        coast_expected.push_back(coast_tally);
        restart_frame();
      end else begin
        at_row = r + 1;
      end
    end else begin
      left_older = left_newest;
      left_newest = cur;
      at_col = c + 1;
    end
  endfunction

  // Driver. A word counts as taken at an edge where valid and ready are both
  // high; only then does it enter the prediction. A new word is offered once
  // the previous one is gone, unless the sender chooses to idle this cycle.
  always @(posedge clk) begin
    if (rst) begin
      char_bus.valid <= 1'b0;
    end else begin
      if (char_bus.valid && char_bus.ready) begin
        predict_coast(char_bus.cell_char);
      end
      if (!char_bus.valid || char_bus.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          char_bus.valid <= 1'b1;
          char_bus.cell_char <= pending_chars.pop_front();
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each total taken is held against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      count_bus.ready <= 1'b0;
    end else begin
      if (count_bus.valid && count_bus.ready) begin
        if (coast_expected.size() == 0) begin
          report_mismatch($sformatf("total %0d arrived with none expected",
                                    count_bus.coast_count));
        end else if (count_bus.coast_count !== coast_expected[0]) begin
          report_mismatch($sformatf("coast_count expected %0d, got %0d",
                                    coast_expected[0], count_bus.coast_count));
          void'(coast_expected.pop_front());
        end else begin
          void'(coast_expected.pop_front());
        end
      end
      count_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hang shows as a long stretch with no handshake on either side.
  always @(posedge clk) begin
    if (rst || cfg_we || (char_bus.valid && char_bus.ready) ||
        (count_bus.valid && count_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write, held for a single cycle. The prediction follows at
  // the edge where the block takes it; writes only happen while it is idle.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROW_COUNT: begin
        grid_rows_reg = data;
        restart_frame();
      end
      CFG_COLUMN_COUNT: begin
        grid_cols_reg = data;
        restart_frame();
      end
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic set_grid(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols);
    write_reg(CFG_ROW_COUNT, rows);
    write_reg(CFG_COLUMN_COUNT, cols);
  endtask

  // Waits until every word is taken and every total has come
  // home, then lets the block run dry.
  task automatic settle();
    while (pending_chars.size() != 0 || char_bus.valid || coast_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_text(string s);
    foreach (s[i]) pending_chars.push_back(s[i]);
  endtask

  // Mostly land and water, with a share of arbitrary bytes that mostly count as neither.
  task automatic queue_cells(int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 45) pending_chars.push_back(CHAR_LAND);
      else if (pick < 85) pending_chars.push_back(CHAR_WATER);
      else pending_chars.push_back(CHAR_W'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int unsigned           mode_words;
    int unsigned           frame_size;
    int unsigned           frames;
    logic [CFG_DATA_W-1:0] rows;
    logic [CFG_DATA_W-1:0] cols;

    char_bus.valid = 1'b0;
    char_bus.cell_char = '0;
    count_bus.ready = 1'b0;
    foreach (row_above[i]) begin
      row_above[i] = CLS_NONE;
      row_above2[i] = CLS_NONE;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hand-made grids. Out of reset the grid is a single cell, which has no
    // neighbour inside the grid and so is never coastal; the byte extremes
    // go through here as well.
    queue_text("#.");
    pending_chars.push_back(CHAR_W'(0));
    pending_chars.push_back(CHAR_W'(255));
    settle();
    // Zero in both registers still means a single cell.
    set_grid(CFG_DATA_W'(0), CFG_DATA_W'(0));
    queue_text("#");
    settle();
    // A single row: the left and right neighbours decide alone.
    set_grid(CFG_DATA_W'(1), CFG_DATA_W'(3));
    queue_text(".#.###");
    settle();
    // A single column: only the cells above and below matter.
    set_grid(CFG_DATA_W'(3), CFG_DATA_W'(1));
    queue_text(".##");
    settle();
    // A lake in the middle of a 3 x 3 island touches four land cells.
    set_grid(CFG_DATA_W'(3), CFG_DATA_W'(3));
    queue_text("####.####");
    settle();

    // Random frames of small sizes under each idling mode in turn. A few
    // frames go back to back with one setting before the next change.
    for (int mode = 0; mode < 4; mode++) begin
      send_idle_pct = SEND_IDLE_PCT[mode];
      recv_stall_pct = RECV_STALL_PCT[mode];
      mode_words = 0;
      while (mode_words < 100) begin
        case ($urandom_range(7))
          0: rows = CFG_DATA_W'(0);
          1: rows = CFG_DATA_W'(1);
          default: rows = CFG_DATA_W'($urandom_range(2, 6));
        endcase
        case ($urandom_range(7))
          0: cols = CFG_DATA_W'(0);
          1: cols = CFG_DATA_W'(1);
          default: cols = CFG_DATA_W'($urandom_range(2, 8));
        endcase
        if ($urandom_range(3) == 0) begin
          write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                    CFG_DATA_W'($urandom_range(2047)));
        end
        set_grid(rows, cols);
        frame_size = clamp_dim(rows, DEF_MAX_ROWS) * clamp_dim(cols, DEF_MAX_COLS);
        frames = $urandom_range(1, 3);
        queue_cells(frame_size * frames);
        mode_words += frame_size * frames;
        settle();
      end
    end

    // Frames broken off half way. A write to an index beyond the list must
    // leave the frame running; a write to a real register starts it afresh
    // and drops the part already sent.
    send_idle_pct = SEND_IDLE_PCT[2];
    recv_stall_pct = RECV_STALL_PCT[2];
    set_grid(CFG_DATA_W'(4), CFG_DATA_W'(5));
    queue_cells(7);
    settle();
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(2047)));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(2047)));
    queue_cells(13);
    settle();
    queue_cells(9);
    settle();
    write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'(5));
    queue_cells(20);
    settle();
    queue_cells(11);
    settle();
    write_reg(CFG_ROW_COUNT, CFG_DATA_W'(3));
    queue_cells(15);
    settle();

    // Register values above the limit clamp to it. Only the start of such a
    // frame is sent, and it must not close a frame.
    send_idle_pct = SEND_IDLE_PCT[3];
    recv_stall_pct = RECV_STALL_PCT[3];
    set_grid(CFG_DATA_W'(2047), CFG_DATA_W'(2047));
    queue_cells(80);
    settle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
